@@ rtl/sobel_edge_magnitude_rgb_defines.svh @@
// Assertion macros used by the checker file.
`ifndef SOBEL_EDGE_MAGNITUDE_RGB_DEFINES_SVH
`define SOBEL_EDGE_MAGNITUDE_RGB_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define SEM_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, sampled on clk, off during reset.
`define SEM_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

@@ rtl/sem_pkg.sv @@
// Shared types, constants and kernels of the Sobel edge magnitude block.
package sem_pkg;

	localparam int MAX_WIDTH_DEF  = 1024;
	localparam int MAX_HEIGHT_DEF = 4096;

	localparam logic [10:0] FRAME_WIDTH_RST  = 11'd1024;
	localparam logic [12:0] FRAME_HEIGHT_RST = 13'd1024;

	localparam logic [0:0] REG_FRAME_WIDTH  = 1'b0;
	localparam logic [0:0] REG_FRAME_HEIGHT = 1'b1;

	localparam logic [20:0] SAT_LIMIT = 21'd65280;
	localparam logic [7:0]  PIX_MAX   = 8'd255;
	localparam int          ROOT_BITS = 8;

	typedef logic signed [2:0] coef_t;
	localparam coef_t KX [9] = '{-3'sd1, 3'sd0, 3'sd1, -3'sd2, 3'sd0, 3'sd2, -3'sd1, 3'sd0, 3'sd1};
	localparam coef_t KY [9] = '{-3'sd1, -3'sd2, -3'sd1, 3'sd0, 3'sd0, 3'sd0, 3'sd1, 3'sd2, 3'sd1};

	// Controller to datapath commands.
	typedef struct packed {
		logic       take;     // latch input beat, advance position
		logic       rd;       // read line stores
		logic       upd;      // write line stores, shift window
		logic       sum;      // form Gx/Gy for selected centre
		logic       sq;       // form sum of squares
		logic       root;     // one square-root bit
		logic       rnd;      // round, clamp, load output register
		logic [1:0] sel;      // centre select: bit1 row offset, bit0 col offset
		logic [2:0] bit_idx;  // root bit under test
		logic       last;     // final result of this input beat
	} sem_cmd_t;

	// Datapath to controller status.
	typedef struct packed {
		logic [3:0] pend;     // centres made ready by the current beat
	} sem_sts_t;

endpackage

@@ rtl/sem_ctrl.sv @@
// Sequencing controller for the Sobel edge magnitude block.
module sem_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	input  sem_pkg::sem_sts_t  sts,
	output sem_pkg::sem_cmd_t  cmd
);

	typedef enum logic [7:0] {
		S_IDLE = 8'b0000_0001,
		S_RD   = 8'b0000_0010,
		S_UPD  = 8'b0000_0100,
		S_SUM  = 8'b0000_1000,
		S_SQ   = 8'b0001_0000,
		S_ROOT = 8'b0010_0000,
		S_RND  = 8'b0100_0000,
		S_OUT  = 8'b1000_0000
	} state_t;

	state_t     state_q;
	logic [3:0] pend_q;
	logic [2:0] cnt_q;
	logic [1:0] sel;
	logic [3:0] low_bit;
	logic [3:0] rest;

	// lowest pending centre goes first (raster order)
	always_comb begin
		priority if (pend_q[0]) sel = 2'd0;
		else if (pend_q[1])     sel = 2'd1;
		else if (pend_q[2])     sel = 2'd2;
		else                    sel = 2'd3;
	end

	assign low_bit = pend_q & (~pend_q + 4'd1);
	assign rest    = pend_q & ~low_bit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pend_q  <= '0;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) state_q <= S_RD;
				end
				S_RD: state_q <= S_UPD;
				S_UPD: begin
					pend_q  <= sts.pend;
					state_q <= (sts.pend == '0) ? S_IDLE : S_SUM;
				end
				S_SUM: state_q <= S_SQ;
				S_SQ: begin
					cnt_q   <= 3'(sem_pkg::ROOT_BITS - 1);
					state_q <= S_ROOT;
				end
				S_ROOT: begin
					if (cnt_q == '0) state_q <= S_RND;
					else cnt_q <= cnt_q - 3'd1;
				end
				S_RND: state_q <= S_OUT;
				S_OUT: begin
					if (out_ready) begin
						pend_q  <= rest;
						state_q <= (rest == '0) ? S_IDLE : S_SUM;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = (state_q == S_OUT);

	always_comb begin
		cmd         = '0;
		cmd.take    = (state_q == S_IDLE) && in_valid;
		cmd.rd      = (state_q == S_RD);
		cmd.upd     = (state_q == S_UPD);
		cmd.sum     = (state_q == S_SUM);
		cmd.sq      = (state_q == S_SQ);
		cmd.root    = (state_q == S_ROOT);
		cmd.rnd     = (state_q == S_RND);
		cmd.sel     = sel;
		cmd.bit_idx = cnt_q;
		cmd.last    = (rest == '0);
	end

endmodule

@@ rtl/sem_dp.sv @@
// Datapath: line stores, 3x3 window, Sobel sums, iterative square root.
module sem_dp #(
	parameter int MAX_WIDTH  = sem_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = sem_pkg::MAX_HEIGHT_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               clr,
	input  logic [10:0]        frame_width,
	input  logic [12:0]        frame_height,
	input  sem_pkg::sem_cmd_t  cmd,
	output sem_pkg::sem_sts_t  sts,
	input  logic [7:0]         in_blue,
	input  logic [7:0]         in_green,
	input  logic [7:0]         in_red,
	output logic [7:0]         out_blue,
	output logic [7:0]         out_green,
	output logic [7:0]         out_red,
	output logic [11:0]        out_row,
	output logic [9:0]         out_col,
	output logic               last_of_run,
	output logic               frame_done
);

	localparam int CW  = $clog2(MAX_WIDTH);
	localparam int RW  = $clog2(MAX_HEIGHT);
	localparam int EWW = $clog2(MAX_WIDTH + 1);
	localparam int EHW = $clog2(MAX_HEIGHT + 1);

	logic [EWW-1:0] eff_w;
	logic [EHW-1:0] eff_h;

	always_comb begin
		if (frame_width == '0) eff_w = EWW'(1);
		else if (32'(frame_width) > 32'(MAX_WIDTH)) eff_w = EWW'(MAX_WIDTH);
		else eff_w = EWW'(frame_width);
		if (frame_height == '0) eff_h = EHW'(1);
		else if (32'(frame_height) > 32'(MAX_HEIGHT)) eff_h = EHW'(MAX_HEIGHT);
		else eff_h = EHW'(frame_height);
	end

	// position of next input beat
	logic [RW-1:0] in_row_q;
	logic [CW-1:0] in_col_q;
	logic          lc, lr;

	assign lc = (EWW'(in_col_q) + EWW'(1)) == eff_w;
	assign lr = (EHW'(in_row_q) + EHW'(1)) == eff_h;

	// current beat
	logic [RW-1:0] cur_r_q;
	logic [CW-1:0] cur_c_q;
	logic          lc_q, lr_q;
	logic [23:0]   pix_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_row_q <= '0;
			in_col_q <= '0;
		end else if (clr) begin
			in_row_q <= '0;
			in_col_q <= '0;
		end else if (cmd.take) begin
			if (lc) begin
				in_col_q <= '0;
				in_row_q <= lr ? '0 : in_row_q + RW'(1);
			end else begin
				in_col_q <= in_col_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			cur_r_q <= in_row_q;
			cur_c_q <= in_col_q;
			lc_q    <= lc;
			lr_q    <= lr;
			pix_q   <= {in_red, in_green, in_blue};
		end
	end

	// line stores: row above and row two above
	logic [23:0] mem_mid [MAX_WIDTH];
	logic [23:0] mem_top [MAX_WIDTH];
	logic [23:0] rd_mid_q, rd_top_q;

	always_ff @(posedge clk) begin
		if (cmd.rd) begin
			rd_mid_q <= mem_mid[cur_c_q];
			rd_top_q <= mem_top[cur_c_q];
		end
		if (cmd.upd) begin
			mem_mid[cur_c_q] <= pix_q;
			mem_top[cur_c_q] <= rd_mid_q;
		end
	end

	// 3x3 window, [row][col], col 2 newest
	logic [23:0] win_q [3][3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 3; k++)
				for (int l = 0; l < 3; l++)
					win_q[k][l] <= '0;
		end else if (clr) begin
			for (int k = 0; k < 3; k++)
				for (int l = 0; l < 3; l++)
					win_q[k][l] <= '0;
		end else if (cmd.upd) begin
			for (int k = 0; k < 3; k++) begin
				win_q[k][0] <= win_q[k][1];
				win_q[k][1] <= win_q[k][2];
			end
			win_q[0][2] <= rd_top_q;
			win_q[1][2] <= rd_mid_q;
			win_q[2][2] <= pix_q;
		end
	end

	assign sts.pend = {lr_q && lc_q,
	                   lr_q && (cur_c_q != '0),
	                   (cur_r_q != '0) && lc_q,
	                   (cur_r_q != '0) && (cur_c_q != '0)};

	// selected centre
	logic          dr, dc;
	logic [RW-1:0] ci;
	logic [CW-1:0] cj;
	logic [2:0]    rok, cok;

	assign dr = cmd.sel[1];
	assign dc = cmd.sel[0];
	assign ci = dr ? cur_r_q : cur_r_q - RW'(1);
	assign cj = dc ? cur_c_q : cur_c_q - CW'(1);
	assign rok = {(EHW'(ci) + EHW'(2)) <= eff_h, 1'b1, ci != '0};
	assign cok = {(EWW'(cj) + EWW'(2)) <= eff_w, 1'b1, cj != '0};

	logic signed [10:0] gx [3];
	logic signed [10:0] gy [3];

	always_comb begin
		logic [23:0] tap;
		logic [7:0]  v;
		for (int ch = 0; ch < 3; ch++) begin
			gx[ch] = '0;
			gy[ch] = '0;
		end
		for (int k = 0; k < 3; k++) begin
			for (int l = 0; l < 3; l++) begin
				tap = '0;
				if ((k + int'(dr)) <= 2 && (l + int'(dc)) <= 2 && rok[k] && cok[l])
					tap = win_q[k + int'(dr)][l + int'(dc)];
				for (int ch = 0; ch < 3; ch++) begin
					v = tap[8*ch +: 8];
					gx[ch] = gx[ch] + $signed({3'b000, v}) * 11'(signed'(sem_pkg::KX[3*k + l]));
					gy[ch] = gy[ch] + $signed({3'b000, v}) * 11'(signed'(sem_pkg::KY[3*k + l]));
				end
			end
		end
	end

	logic signed [10:0] gx_s1 [3];
	logic signed [10:0] gy_s1 [3];
	logic signed [21:0] px2 [3];
	logic signed [21:0] py2 [3];
	logic [20:0]        s_q [3];
	logic [7:0]         root_q [3];
	logic [15:0]        r2_q [3];
	logic [7:0]         t [3];
	logic [15:0]        tt [3];
	logic [20:0]        diff [3];
	logic [7:0]         res [3];

	always_comb begin
		for (int ch = 0; ch < 3; ch++) begin
			px2[ch]  = gx_s1[ch] * gx_s1[ch];
			py2[ch]  = gy_s1[ch] * gy_s1[ch];
			t[ch]    = root_q[ch] | (8'd1 << cmd.bit_idx);
			tt[ch]   = t[ch] * t[ch];
			diff[ch] = s_q[ch] - 21'(r2_q[ch]);
			if (s_q[ch] > sem_pkg::SAT_LIMIT)
				res[ch] = sem_pkg::PIX_MAX;
			else if (diff[ch] > 21'(root_q[ch]) && root_q[ch] != sem_pkg::PIX_MAX)
				res[ch] = root_q[ch] + 8'd1;
			else
				res[ch] = root_q[ch];
		end
	end

	always_ff @(posedge clk) begin
		for (int ch = 0; ch < 3; ch++) begin
			if (cmd.sum) begin
				gx_s1[ch] <= gx[ch];
				gy_s1[ch] <= gy[ch];
			end
			if (cmd.sq) begin
				s_q[ch]    <= 21'(px2[ch]) + 21'(py2[ch]);
				root_q[ch] <= '0;
				r2_q[ch]   <= '0;
			end
			if (cmd.root && (21'(tt[ch]) <= s_q[ch])) begin
				root_q[ch] <= t[ch];
				r2_q[ch]   <= tt[ch];
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.rnd) begin
			out_blue    <= res[0];
			out_green   <= res[1];
			out_red     <= res[2];
			out_row     <= 12'(ci);
			out_col     <= 10'(cj);
			last_of_run <= cmd.last;
			frame_done  <= (cmd.sel == 2'd3);
		end
	end

endmodule

@@ rtl/sobel_edge_magnitude_rgb.sv @@
// Top level: RGB 3x3 Sobel edge magnitude with APB configuration.
// Sequence per input beat: accept, read line stores, update window, then per result Sobel sums,
//   sum of squares, bit-serial square root (three channels in parallel), round, offer.
// A beat releases n = 0..4 results; the next beat is taken only after its last result.
// Each further result of the same beat starts its pass once the prior result is taken.
// Reset (arst_n low, asynchronous): frame position and window cleared, width and
//   height back to 1024; line stores are not cleared and need no clearing pass.
module sobel_edge_magnitude_rgb #(
	parameter int MAX_WIDTH  = sem_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = sem_pkg::MAX_HEIGHT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// pixel in
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  in_blue,
	input  logic [7:0]  in_green,
	input  logic [7:0]  in_red,
	// result out
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_blue,
	output logic [7:0]  out_green,
	output logic [7:0]  out_red,
	output logic [11:0] out_row,
	output logic [9:0]  out_col,
	output logic        last_of_run,
	output logic        frame_done
);

	logic [10:0] frame_width_q;
	logic [12:0] frame_height_q;
	logic        cfg_wr;

	sem_pkg::sem_cmd_t cmd;
	sem_pkg::sem_sts_t sts;

	// Register file: word index is paddr[2]. Any write restarts the frame.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= sem_pkg::FRAME_WIDTH_RST;
			frame_height_q <= sem_pkg::FRAME_HEIGHT_RST;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				sem_pkg::REG_FRAME_WIDTH:  frame_width_q  <= pwdata[10:0];
				sem_pkg::REG_FRAME_HEIGHT: frame_height_q <= pwdata[12:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			sem_pkg::REG_FRAME_WIDTH:  prdata = 32'(frame_width_q);
			sem_pkg::REG_FRAME_HEIGHT: prdata = 32'(frame_height_q);
			default:                   prdata = '0;
		endcase
	end

	// controller: one beat at a time, then one result per pass
	sem_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// datapath: line stores, window, Sobel sums, square root, result register
	sem_dp #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.clr          (cfg_wr),
		.frame_width  (frame_width_q),
		.frame_height (frame_height_q),
		.cmd          (cmd),
		.sts          (sts),
		.in_blue      (in_blue),
		.in_green     (in_green),
		.in_red       (in_red),
		.out_blue     (out_blue),
		.out_green    (out_green),
		.out_red      (out_red),
		.out_row      (out_row),
		.out_col      (out_col),
		.last_of_run  (last_of_run),
		.frame_done   (frame_done)
	);

endmodule

@@ rtl/sem_checker.sv @@
// Port-level checker for the Sobel edge magnitude block, bound to the top level.
`include "sobel_edge_magnitude_rgb_defines.svh"

module sem_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [7:0]  out_blue,
	input logic [7:0]  out_green,
	input logic [7:0]  out_red,
	input logic [11:0] out_row,
	input logic [9:0]  out_col,
	input logic        last_of_run,
	input logic        frame_done
);

	// a stalled result beat holds
	`SEM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable({out_blue, out_green, out_red, out_row, out_col, last_of_run, frame_done}))
	// no new pixel is taken while a result is on offer
	`SEM_ASSERT_NOW(a_excl, out_valid, !in_ready)
	// one pixel at a time
	`SEM_ASSERT_NEXT(a_one_beat, in_valid && in_ready, !in_ready)
	// the bottom-right result always closes its run
	`SEM_ASSERT_NOW(a_done_last, out_valid && frame_done, last_of_run)

endmodule

bind sobel_edge_magnitude_rgb sem_checker u_sem_checker (.*);
